// ===== design/bts_pkg.sv =====
// shared types and constants of the bilinear texture sampler
`default_nettype none
package bts_pkg;

   localparam int CHAN_W     = 8;
   localparam int NUM_CHAN   = 4;
   localparam int TEXEL_W    = CHAN_W * NUM_CHAN;
   localparam int OUT_W      = 16;
   localparam int COORD_W    = 24;
   localparam int CFG_W      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = 2;
   localparam int RSP_CNT_W  = 3;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_LOG2  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LOG2 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOUR_CHAN   = 2'd2;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 4'd8;

   // phase of a texel read: bit 0 selects x1, bit 1 selects y1
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_LAST  = 2'd3;

   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic       valid;
      logic       is_sample;
      logic [1:0] phase;
   } bts_tag_type;

   typedef struct packed {
      logic                           is_sample;
      logic [NUM_CHAN-1:0][OUT_W-1:0] color;   // index 0 red .. 3 alpha
   } bts_rsp_type;

endpackage
`default_nettype wire

// ===== design/bts_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/bts_fetch.sv =====
// address generation and texture memory access sequencing
`default_nettype none
module bts_fetch #(
   parameter int MAX_DIM_LOG2 = 8,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                take,
   output logic                                     free,
   input  wire logic                                req_mode,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_texel_col,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_texel_row,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_red_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_green_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_blue_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]          req_alpha_in,
   input  wire logic [bts_pkg::COORD_W-1:0]         req_u_coord,
   input  wire logic [bts_pkg::COORD_W-1:0]         req_v_coord,
   input  wire logic [bts_pkg::CFG_W-1:0]           width_log2,
   input  wire logic [bts_pkg::CFG_W-1:0]           height_log2,
   input  wire logic                                four_channels,
   output logic                                     mem_wr_en,
   output logic                                     mem_rd_en,
   output logic      [2*MAX_DIM_LOG2-1:0]           mem_addr,
   output logic      [bts_pkg::TEXEL_W-1:0]         mem_wdata,
   output bts_pkg::bts_tag_type                     tag,
   output logic      [FRAC_BITS-1:0]                s_frac,
   output logic      [FRAC_BITS-1:0]                t_frac
);
   import bts_pkg::*;

   localparam int DW  = MAX_DIM_LOG2;
   localparam int SUW = COORD_W + MAX_DIM_LOG2;

   logic [DW-1:0]      wmask;
   logic [DW-1:0]      hmask;
   logic [SUW-1:0]     su;
   logic [SUW-1:0]     sv;
   logic [DW+7:0]      col_ext;
   logic [DW+7:0]      row_ext;
   logic [DW-1:0]      x0;
   logic [DW-1:0]      y0;
   logic [DW-1:0]      x1;
   logic [DW-1:0]      y1;
   logic [DW-1:0]      wcol;
   logic [DW-1:0]      wrow;
   logic [CHAN_W-1:0]  alpha;
   logic               op_last;
   logic [DW-1:0]      col_sel;
   logic [DW-1:0]      row_sel;

   logic               op_valid_ff, op_valid_in;
   logic               op_sample_ff, op_sample_in;
   logic [1:0]         phase_ff, phase_in;
   logic [DW-1:0]      x0_ff, x0_in;
   logic [DW-1:0]      x1_ff, x1_in;
   logic [DW-1:0]      y0_ff, y0_in;
   logic [DW-1:0]      y1_ff, y1_in;
   logic [FRAC_BITS-1:0] s_ff, s_in;
   logic [FRAC_BITS-1:0] t_ff, t_in;
   logic [TEXEL_W-1:0] wdata_ff, wdata_in;

   // wrap masks for the current texture size
   assign wmask = ~({DW{1'b1}} << width_log2);
   assign hmask = ~({DW{1'b1}} << height_log2);

   assign su = SUW'(req_u_coord) << width_log2;
   assign sv = SUW'(req_v_coord) << height_log2;
   assign x0 = su[FRAC_BITS +: DW] & wmask;
   assign y0 = sv[FRAC_BITS +: DW] & hmask;
   assign x1 = DW'(x0 + DW'(1)) & wmask;
   assign y1 = DW'(y0 + DW'(1)) & hmask;

   assign col_ext = {{DW{1'b0}}, req_texel_col};
   assign row_ext = {{DW{1'b0}}, req_texel_row};
   assign wcol    = col_ext[DW-1:0] & wmask;
   assign wrow    = row_ext[DW-1:0] & hmask;
   assign alpha   = four_channels ? req_alpha_in : ALPHA_OPAQUE;

   assign op_last = !op_sample_ff || (phase_ff == PHASE_LAST);
   assign free    = !op_valid_ff || op_last;

   always_comb begin
      op_valid_in  = op_valid_ff;
      op_sample_in = op_sample_ff;
      phase_in     = phase_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      wdata_in     = wdata_ff;
      priority if (take) begin
         op_valid_in  = 1'b1;
         op_sample_in = (req_mode == MODE_SAMPLE);
         phase_in     = PHASE_FIRST;
         if (req_mode == MODE_SAMPLE) begin
            x0_in = x0;
            x1_in = x1;
            y0_in = y0;
            y1_in = y1;
         end else begin
            x0_in = wcol;
            x1_in = wcol;
            y0_in = wrow;
            y1_in = wrow;
         end
         s_in     = su[FRAC_BITS-1:0];
         t_in     = sv[FRAC_BITS-1:0];
         wdata_in = {alpha, req_blue_in, req_green_in, req_red_in};
      end else if (op_valid_ff && op_last) begin
         op_valid_in = 1'b0;
      end else begin
         // phase of an idle slot is never looked at
         phase_in = phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff <= 1'b0;
      end else begin
         op_valid_ff <= op_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_sample_ff <= op_sample_in;
      phase_ff     <= phase_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y0_ff        <= y0_in;
      y1_ff        <= y1_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      wdata_ff     <= wdata_in;
   end

   // reads go in the order (x0,y0) (x1,y0) (x0,y1) (x1,y1)
   assign col_sel   = phase_ff[0] ? x1_ff : x0_ff;
   assign row_sel   = phase_ff[1] ? y1_ff : y0_ff;
   assign mem_addr  = {row_sel, col_sel};
   assign mem_wr_en = op_valid_ff && !op_sample_ff;
   assign mem_rd_en = op_valid_ff && op_sample_ff;
   assign mem_wdata = wdata_ff;

   assign tag.valid     = op_valid_ff;
   assign tag.is_sample = op_sample_ff;
   assign tag.phase     = op_sample_ff ? phase_ff : PHASE_LAST;
   assign s_frac        = s_ff;
   assign t_frac        = t_ff;

`ifndef SYNTH
   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      take && req_mode == MODE_SAMPLE |=> mem_rd_en && phase_ff == PHASE_FIRST)
      else $error("sample did not start its reads right after the transfer");

   a_reads_no_gap: assert property (@(posedge clock) disable iff (reset)
      op_valid_ff && op_sample_ff && phase_ff != PHASE_LAST
      |=> op_valid_ff && op_sample_ff && phase_ff == $past(phase_ff) + 2'd1)
      else $error("texel reads of one sample were interrupted");
`endif

endmodule
`default_nettype wire

// ===== design/bts_filter.sv =====
// bilinear blend pipeline and result queue
`default_nettype none
module bts_filter #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire bts_pkg::bts_tag_type         tag,
   input  wire logic [FRAC_BITS-1:0]         s_frac,
   input  wire logic [FRAC_BITS-1:0]         t_frac,
   input  wire logic [bts_pkg::TEXEL_W-1:0]  rd_data,
   input  wire logic                         rsp_pop,
   output logic                              rsp_valid,
   output bts_pkg::bts_rsp_type              rsp
);
   import bts_pkg::*;

   localparam int HPW  = CHAN_W + FRAC_BITS;
   localparam int WW   = FRAC_BITS + 1;
   localparam int PW   = CHAN_W + FRAC_BITS + 1;
   localparam int ACCW = CHAN_W + 2 * FRAC_BITS;
   localparam int SHR  = 2 * FRAC_BITS - 8;
   localparam logic [WW-1:0]   ONE   = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACCW-1:0] ROUND = ACCW'(1) << (2 * FRAC_BITS - 9);

   // texel read data arrives in the cycle after its tag, so the tag is delayed to line up
   bts_tag_type          tag_d_ff;
   logic [FRAC_BITS-1:0] s_d_ff;
   logic [FRAC_BITS-1:0] t_d_ff;

   bts_tag_type                   a_tag_ff;
   logic [FRAC_BITS-1:0]          a_t_ff;
   logic [NUM_CHAN-1:0][HPW-1:0]  a_hp_ff, a_hp_in;
   logic [WW-1:0]                 hw;
   logic [PW-1:0]                 hprod [NUM_CHAN];

   logic [NUM_CHAN-1:0][HPW-1:0]  hold_ff;
   logic                          hold_we;
   bts_tag_type                   b_tag_ff, b_tag_in;
   logic [NUM_CHAN-1:0][HPW-1:0]  b_h_ff, b_h_in;
   logic [WW-1:0]                 b_vw_ff, b_vw_in;

   bts_tag_type                   c_tag_ff;
   logic [NUM_CHAN-1:0][ACCW-1:0] c_vp_ff, c_vp_in;

   logic [NUM_CHAN-1:0][ACCW-1:0] vhold_ff;
   logic                          vhold_we;
   logic [ACCW-1:0]               vsum [NUM_CHAN];
   logic                          push;
   bts_rsp_type                   push_data;

   bts_rsp_type                   fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]          cnt_ff, cnt_in;

   // horizontal weight times texel byte
   always_comb begin
      hw = tag_d_ff.phase[0] ? {1'b0, s_d_ff} : ONE - {1'b0, s_d_ff};
      for (int k = 0; k < NUM_CHAN; k++) begin
         hprod[k]   = PW'(rd_data[k*CHAN_W +: CHAN_W]) * PW'(hw);
         a_hp_in[k] = hprod[k][HPW-1:0];
      end
   end

   // pair sum across, then choose the vertical weight
   always_comb begin
      hold_we        = a_tag_ff.valid && a_tag_ff.is_sample && !a_tag_ff.phase[0];
      b_tag_in       = a_tag_ff;
      b_tag_in.valid = a_tag_ff.valid && (a_tag_ff.phase[0] || !a_tag_ff.is_sample);
      b_vw_in        = a_tag_ff.phase[1] ? {1'b0, a_t_ff} : ONE - {1'b0, a_t_ff};
      for (int k = 0; k < NUM_CHAN; k++) begin
         b_h_in[k] = HPW'(hold_ff[k] + a_hp_ff[k]);
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         c_vp_in[k] = ACCW'(ACCW'(b_h_ff[k]) * ACCW'(b_vw_ff));
      end
   end

   // top row waits for bottom row, then round and scale to 8.8
   always_comb begin
      vhold_we            = c_tag_ff.valid && c_tag_ff.is_sample && !c_tag_ff.phase[1];
      push                = c_tag_ff.valid && (c_tag_ff.phase[1] || !c_tag_ff.is_sample);
      push_data.is_sample = c_tag_ff.is_sample;
      for (int k = 0; k < NUM_CHAN; k++) begin
         vsum[k] = ACCW'(vhold_ff[k] + c_vp_ff[k] + ROUND);
         push_data.color[k] = c_tag_ff.is_sample ? vsum[k][SHR +: OUT_W] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff <= '0;
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
      end else begin
         tag_d_ff <= tag;
         a_tag_ff <= tag_d_ff;
         b_tag_ff <= b_tag_in;
         c_tag_ff <= b_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      s_d_ff  <= s_frac;
      t_d_ff  <= t_frac;
      a_t_ff  <= t_d_ff;
      a_hp_ff <= a_hp_in;
      b_h_ff  <= b_h_in;
      b_vw_ff <= b_vw_in;
      c_vp_ff <= c_vp_in;
      if (hold_we) begin
         hold_ff <= a_hp_ff;
      end
      if (vhold_we) begin
         vhold_ff <= c_vp_ff;
      end
   end

   // result queue, space is reserved before an item enters
   always_comb begin
      wr_ptr_in = push ? RSP_PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = rsp_pop ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = RSP_CNT_W'(cnt_ff + RSP_CNT_W'(push) - RSP_CNT_W'(rsp_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp       = fifo_ff[rd_ptr_ff];

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> cnt_ff != RSP_CNT_W'(RSP_DEPTH) || rsp_pop)
      else $error("result queue written while full");
`endif

endmodule
`default_nettype wire

// ===== design/bilinear_texture_sampler_unit.sv =====
// top level of the bilinear texture sampler
`default_nettype none
// Holds one RGBA8 texture of up to 2^MAX_DIM_LOG2 x 2^MAX_DIM_LOG2 texels in a
// single synchronous RAM and serves two kinds of request: a write stores one
// texel, a sample returns the bilinear blend of the four texels around (u,v)
// with wrap-around addressing, each channel in 8.8 fixed point. The RAM has one
// access per cycle, so the input is held busy while a sample makes its four
// texel reads, and a write takes a single access; each result goes through the
// RAM read register and the blend pipeline before it is offered.
// At most 4 items may be outstanding (accepted, result not yet taken), counting
// those still in the pipeline, so the input stalls once 4 are outstanding:
// back-to-back samples with the output always ready never reach that bound,
// back-to-back writes reach it and then wait for results to be taken. The
// texture is not cleared at reset: sample only texels that have been written.
// Change the csr registers only while no request is in flight.
module bilinear_texture_sampler_unit #(
   parameter int MAX_DIM_LOG2 = 8,
   parameter int FRAC_BITS    = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_texel_col,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_texel_row,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_red_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_green_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_blue_in,
   input  wire logic [bts_pkg::CHAN_W-1:0]        req_alpha_in,
   input  wire logic [bts_pkg::COORD_W-1:0]       req_u_coord,
   input  wire logic [bts_pkg::COORD_W-1:0]       req_v_coord,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_is_sample,
   output logic      [bts_pkg::OUT_W-1:0]         rsp_red_out,
   output logic      [bts_pkg::OUT_W-1:0]         rsp_green_out,
   output logic      [bts_pkg::OUT_W-1:0]         rsp_blue_out,
   output logic      [bts_pkg::OUT_W-1:0]         rsp_alpha_out,
   input  wire logic                              csr_we,
   input  wire logic [bts_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bts_pkg::CFG_W-1:0]         csr_wdata
);
   import bts_pkg::*;

   localparam int AW = 2 * MAX_DIM_LOG2;
   localparam logic [CFG_W-1:0] MAX_LOG2 = CFG_W'(MAX_DIM_LOG2);

   logic [CFG_W-1:0]     width_log2_ff, width_log2_in;
   logic [CFG_W-1:0]     height_log2_ff, height_log2_in;
   logic                 four_chan_ff, four_chan_in;
   logic [CFG_W-1:0]     wl;
   logic [CFG_W-1:0]     hl;

   logic [RSP_CNT_W-1:0] pend_ff, pend_in;
   logic                 take;
   logic                 pop;
   logic                 fetch_free;

   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_addr;
   logic [TEXEL_W-1:0]   mem_wdata;
   logic [TEXEL_W-1:0]   mem_rdata;
   bts_tag_type          tag;
   logic [FRAC_BITS-1:0] s_frac;
   logic [FRAC_BITS-1:0] t_frac;
   bts_rsp_type          rsp;

   always_comb begin
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      four_chan_in   = four_chan_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH_LOG2:  width_log2_in  = csr_wdata;
            CSR_HEIGHT_LOG2: height_log2_in = csr_wdata;
            CSR_FOUR_CHAN:   four_chan_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= CFG_SIZE_RESET;
         height_log2_ff <= CFG_SIZE_RESET;
         four_chan_ff   <= 1'b1;
      end else begin
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         four_chan_ff   <= four_chan_in;
      end
   end

   // oversized sizes act as the largest texture
   assign wl = (width_log2_ff > MAX_LOG2) ? MAX_LOG2 : width_log2_ff;
   assign hl = (height_log2_ff > MAX_LOG2) ? MAX_LOG2 : height_log2_ff;

   // items accepted and not yet delivered, bounded by the result queue
   assign take      = req_valid && req_ready;
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = fetch_free && (pend_ff != RSP_CNT_W'(RSP_DEPTH));
   assign pend_in   = RSP_CNT_W'(pend_ff + RSP_CNT_W'(take) - RSP_CNT_W'(pop));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   bts_fetch #(
      .MAX_DIM_LOG2 (MAX_DIM_LOG2),
      .FRAC_BITS    (FRAC_BITS)
   ) u_fetch (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .free          (fetch_free),
      .req_mode      (req_mode),
      .req_texel_col (req_texel_col),
      .req_texel_row (req_texel_row),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .req_alpha_in  (req_alpha_in),
      .req_u_coord   (req_u_coord),
      .req_v_coord   (req_v_coord),
      .width_log2    (wl),
      .height_log2   (hl),
      .four_channels (four_chan_ff),
      .mem_wr_en     (mem_wr_en),
      .mem_rd_en     (mem_rd_en),
      .mem_addr      (mem_addr),
      .mem_wdata     (mem_wdata),
      .tag           (tag),
      .s_frac        (s_frac),
      .t_frac        (t_frac)
   );

   bts_ram #(
      .WIDTH (TEXEL_W),
      .DEPTH (1 << AW)
   ) u_texture_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   bts_filter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_filter (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag),
      .s_frac    (s_frac),
      .t_frac    (t_frac),
      .rd_data   (mem_rdata),
      .rsp_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_is_sample = rsp.is_sample;
   assign rsp_red_out   = rsp.color[0];
   assign rsp_green_out = rsp.color[1];
   assign rsp_blue_out  = rsp.color[2];
   assign rsp_alpha_out = rsp.color[3];

`ifndef SYNTH
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("outstanding item count beyond result queue depth");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result offered with no item outstanding");
`endif

endmodule
`default_nettype wire
